@@ sv/adaptive_roughness_smoother_macros.svh @@
// Assertion macros shared by the roughness smoother modules.
`ifndef ADAPTIVE_ROUGHNESS_SMOOTHER_MACROS_SVH
`define ADAPTIVE_ROUGHNESS_SMOOTHER_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge once reset is released.
`define ARS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ars assertion failed");
// Condition that must never be seen outside reset.
`define ARS_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ars forbidden condition seen");
`else
`define ARS_ASSERT(label, prop)
`define ARS_NEVER(label, expr)
`endif
`endif

@@ sv/ars_pkg.sv @@
// Shared constants, types and command structs for the roughness smoother.
package ars_pkg;

    localparam int BLOCK_FRAMES = 64;
    localparam int CHANNELS     = 2;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 16;
    localparam int ADDR_W       = $clog2(BLOCK_FRAMES);
    localparam int COUNT_W      = $clog2(BLOCK_FRAMES + 1);
    localparam int PEAK_W       = SAMPLE_W + 1;
    localparam int EX_W         = PEAK_W + 4;
    localparam int E_W          = 24;
    localparam int V_W          = 18;

    // shared multiplier geometry
    localparam int MUL_A_W      = 25;
    localparam int MUL_B_W      = 18;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;

    localparam int THRESHOLD    = 419430;
    localparam int ONE_Q23      = 8388608;
    localparam int CAP_Q16      = 19661;
    localparam int BYPASS_LIMIT = 66;
    localparam int ROUND_HALF   = 32768;
    localparam int FRAC_W       = 16;
    localparam int STR_SHIFT    = 23;
    localparam int INT_SHIFT    = 16;
    localparam int V_ROUND      = 5;
    // divide by ten as multiply by ceil(2^20 / 10), exact for v < 2^18
    localparam int RECIP_10     = 104858;
    localparam int RECIP_SHIFT  = 20;

    // configuration port
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 2;
    localparam logic [REG_IDX_W-1:0] REG_STRENGTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTENSITY = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEFF     = 2'd2;
    localparam logic [COEF_W-1:0] STRENGTH_RESET  = 16'd65535;
    localparam logic [COEF_W-1:0] INTENSITY_RESET = 16'd65535;
    localparam logic [COEF_W-1:0] COEFF_RESET     = 16'd4025;

    // multiplier operand selects
    localparam int MOP_W = 3;
    localparam logic [MOP_W-1:0] MOP_NONE = 3'd0;
    localparam logic [MOP_W-1:0] MOP_LP   = 3'd1;
    localparam logic [MOP_W-1:0] MOP_MIX  = 3'd2;
    localparam logic [MOP_W-1:0] MOP_STR  = 3'd3;
    localparam logic [MOP_W-1:0] MOP_INT  = 3'd4;
    localparam logic [MOP_W-1:0] MOP_DIV  = 3'd5;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

    typedef struct packed {
        logic              capture;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              mul_en;
        logic [MOP_W-1:0]  mop;
        logic              calc_e;
        logic              single_frame;
        logic              calc_v;
        logic              upd_amount;
        logic              upd_lowpass;
        logic              emit;
        logic              last;
        logic              bypass;
        logic              clear_block;
    } ars_cmd_t;

    typedef struct packed {
        logic bypass_req;
    } ars_status_t;

endpackage

@@ sv/ars_ctrl.sv @@
// Sequencer for frame capture, blend amount update and block emission.
`include "adaptive_roughness_smoother_macros.svh"
module ars_ctrl
    import ars_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        block_end,
    output logic        busy,
    input  ars_status_t status,
    output ars_cmd_t    cmd
);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_IDLE = 4'd0;
    localparam logic [STATE_W-1:0] S_E    = 4'd1;
    localparam logic [STATE_W-1:0] S_STR  = 4'd2;
    localparam logic [STATE_W-1:0] S_INT  = 4'd3;
    localparam logic [STATE_W-1:0] S_TGT  = 4'd4;
    localparam logic [STATE_W-1:0] S_DIV  = 4'd5;
    localparam logic [STATE_W-1:0] S_AMT  = 4'd6;
    localparam logic [STATE_W-1:0] S_READ = 4'd7;
    localparam logic [STATE_W-1:0] S_MUL1 = 4'd8;
    localparam logic [STATE_W-1:0] S_LPU  = 4'd9;
    localparam logic [STATE_W-1:0] S_MUL2 = 4'd10;
    localparam logic [STATE_W-1:0] S_OUT  = 4'd11;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic               bypass_reg, bypass_next;
    logic               accept;
    logic               full;
    logic               last_frame;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign full       = (count_reg == COUNT_W'(BLOCK_FRAMES - 1));
    assign last_frame = ((COUNT_W'(k_reg) + COUNT_W'(1)) == n_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        bypass_next = bypass_reg;
        cmd         = '0;
        cmd.wr_addr = count_reg[ADDR_W-1:0];
        cmd.mop     = MOP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (block_end || full)
                    begin
                        n_next      = count_reg + COUNT_W'(1);
                        count_next  = '0;
                        k_next      = '0;
                        bypass_next = status.bypass_req;
                        state_next  = status.bypass_req ? S_READ : S_E;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            S_E:
            begin
                cmd.calc_e       = 1'b1;
                cmd.single_frame = (n_reg < COUNT_W'(2));
                state_next       = S_STR;
            end
            S_STR:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = MOP_STR;
                state_next = S_INT;
            end
            S_INT:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = MOP_INT;
                state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.calc_v = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = MOP_DIV;
                state_next = S_AMT;
            end
            S_AMT:
            begin
                cmd.upd_amount = 1'b1;
                state_next     = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = k_reg;
                state_next  = bypass_reg ? S_OUT : S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = MOP_LP;
                state_next = S_LPU;
            end
            S_LPU:
            begin
                cmd.upd_lowpass = 1'b1;
                state_next      = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop    = MOP_MIX;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit   = 1'b1;
                cmd.bypass = bypass_reg;
                cmd.last   = last_frame;
                if (last_frame)
                begin
                    cmd.clear_block = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    // fetch the next frame while this one goes out
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = k_reg + ADDR_W'(1);
                    k_next      = k_reg + ADDR_W'(1);
                    state_next  = bypass_reg ? S_OUT : S_MUL1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            bypass_reg <= bypass_next;
        end
    end

    `ARS_ASSERT(a_count_in_range, count_reg < COUNT_W'(BLOCK_FRAMES))
    `ARS_ASSERT(a_end_leaves_idle, (start && !busy && block_end) |=> (state_reg != S_IDLE))
    `ARS_ASSERT(a_out_index, (state_reg == S_OUT) |-> (COUNT_W'(k_reg) < n_reg))

endmodule

@@ sv/ars_datapath.sv @@
// Frame store, roughness detector, blend amount math and per-channel lowpass lanes.
`include "adaptive_roughness_smoother_macros.svh"
module ars_datapath
    import ars_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ars_cmd_t          cmd,
    output ars_status_t       status,
    input  frame_t            in_frame,
    input  logic [COEF_W-1:0] strength,
    input  logic [COEF_W-1:0] detection_intensity,
    input  logic [COEF_W-1:0] filter_coeff,
    output frame_t            out_frame,
    output logic              out_last,
    output logic              out_strobe
);

    frame_t                     store_mem [BLOCK_FRAMES];
    frame_t                     rd_data_reg;
    logic [SAMPLE_W-1:0]        prev_reg [CHANNELS];
    logic [PEAK_W-1:0]          peak_reg, peak_next;
    logic signed [SAMPLE_W-1:0] z_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] z_next [CHANNELS];
    logic signed [PROD_W-1:0]   prod_reg [CHANNELS];
    logic [E_W-1:0]             e_reg, e_next;
    logic [V_W-1:0]             v_reg, v_next;
    logic [COEF_W-1:0]          amount_reg;
    frame_t                     out_frame_reg, y_next;
    logic                       out_last_reg;
    logic                       strobe_reg;

    logic [PEAK_W-1:0]          diff [CHANNELS];
    logic [PEAK_W-1:0]          diff_abs [CHANNELS];
    logic [PEAK_W-1:0]          peak_eff;
    logic [PEAK_W-1:0]          excess;
    logic [EX_W-1:0]            ex10;
    logic [COEF_W-1:0]          tgt, tgt_cap;
    logic signed [MUL_A_W-1:0]  mul_a [CHANNELS];
    logic signed [MUL_B_W-1:0]  mul_b [CHANNELS];
    logic signed [PROD_W-1:0]   rnd_sum [CHANNELS];
    logic signed [PROD_W-1:0]   rnd_shift [CHANNELS];

    assign status.bypass_req = (strength < COEF_W'(BYPASS_LIMIT)) ||
                               (detection_intensity < COEF_W'(BYPASS_LIMIT));

    // peak of |x - previous| across channels
    always_comb
    begin
        peak_next = peak_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            diff[c]     = PEAK_W'($signed(in_frame[c])) - PEAK_W'($signed(prev_reg[c]));
            diff_abs[c] = diff[c][PEAK_W-1] ? (~diff[c] + PEAK_W'(1)) : diff[c];
            if (diff_abs[c] > peak_next)
            begin
                peak_next = diff_abs[c];
            end
        end
    end

    // excess over threshold times ten, capped at one
    always_comb
    begin
        peak_eff = cmd.single_frame ? '0 : peak_reg;
        excess   = peak_eff - PEAK_W'(THRESHOLD);
        ex10     = (EX_W'(excess) << 3) + (EX_W'(excess) << 1);
        if (peak_eff <= PEAK_W'(THRESHOLD))
        begin
            e_next = '0;
        end
        else if (ex10 > EX_W'(ONE_Q23))
        begin
            e_next = E_W'(ONE_Q23);
        end
        else
        begin
            e_next = ex10[E_W-1:0];
        end
    end

    // new amount numerator: 9 * amount + capped target + 5
    always_comb
    begin
        tgt     = prod_reg[0][INT_SHIFT +: COEF_W];
        tgt_cap = (tgt > COEF_W'(CAP_Q16)) ? COEF_W'(CAP_Q16) : tgt;
        v_next  = (V_W'(amount_reg) << 3) + V_W'(amount_reg) + V_W'(tgt_cap)
                  + V_W'(V_ROUND);
    end

    // operand select per lane; lane 0 also serves the amount math
    always_comb
    begin
        for (int l = 0; l < CHANNELS; l++)
        begin
            mul_a[l] = '0;
            mul_b[l] = '0;
            unique case (cmd.mop)
                MOP_LP:
                begin
                    mul_a[l] = MUL_A_W'($signed(rd_data_reg[l])) - MUL_A_W'(z_reg[l]);
                    mul_b[l] = MUL_B_W'(filter_coeff);
                end
                MOP_MIX:
                begin
                    mul_a[l] = MUL_A_W'(z_reg[l]) - MUL_A_W'($signed(rd_data_reg[l]));
                    mul_b[l] = MUL_B_W'(amount_reg);
                end
                MOP_STR:
                begin
                    mul_a[l] = MUL_A_W'(e_reg);
                    mul_b[l] = MUL_B_W'(strength);
                end
                MOP_INT:
                begin
                    mul_a[l] = MUL_A_W'(prod_reg[0][STR_SHIFT +: COEF_W]);
                    mul_b[l] = MUL_B_W'(detection_intensity);
                end
                MOP_DIV:
                begin
                    mul_a[l] = MUL_A_W'(v_reg);
                    mul_b[l] = MUL_B_W'(RECIP_10);
                end
                default:
                begin
                    mul_a[l] = '0;
                    mul_b[l] = '0;
                end
            endcase
        end
    end

    // (p + 0.5) >> 16, floor; same rounding for lowpass step and blend
    always_comb
    begin
        for (int l = 0; l < CHANNELS; l++)
        begin
            rnd_sum[l]   = prod_reg[l] + PROD_W'(ROUND_HALF);
            rnd_shift[l] = rnd_sum[l] >>> FRAC_W;
            z_next[l]    = z_reg[l] + rnd_shift[l][SAMPLE_W-1:0];
            y_next[l]    = cmd.bypass ? rd_data_reg[l]
                                      : rd_data_reg[l] + rnd_shift[l][SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            store_mem[cmd.wr_addr] <= in_frame;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < CHANNELS; l++)
        begin
            if (cmd.mul_en)
            begin
                prod_reg[l] <= mul_a[l] * mul_b[l];
            end
        end
        if (cmd.calc_v)
        begin
            v_reg <= v_next;
        end
        if (cmd.emit)
        begin
            out_frame_reg <= y_next;
            out_last_reg  <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            e_reg      <= '0;
            amount_reg <= '0;
            strobe_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                prev_reg[c] <= '0;
                z_reg[c]    <= '0;
            end
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.capture)
            begin
                peak_reg <= peak_next;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    prev_reg[c] <= in_frame[c];
                end
            end
            else if (cmd.clear_block)
            begin
                peak_reg <= '0;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    prev_reg[c] <= '0;
                end
            end
            if (cmd.calc_e)
            begin
                e_reg <= e_next;
            end
            if (cmd.upd_amount)
            begin
                amount_reg <= prod_reg[0][RECIP_SHIFT +: COEF_W];
            end
            if (cmd.upd_lowpass)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    z_reg[c] <= z_next[c];
                end
            end
        end
    end

    assign out_frame  = out_frame_reg;
    assign out_last   = out_last_reg;
    assign out_strobe = strobe_reg;

    `ARS_ASSERT(a_amount_capped, amount_reg <= COEF_W'(CAP_Q16))
    `ARS_ASSERT(a_excess_capped, e_reg <= E_W'(ONE_Q23))
    `ARS_ASSERT(a_lowpass_hold, $stable(z_reg[0]) || $past(cmd.upd_lowpass))
    `ARS_NEVER(a_capture_during_clear, cmd.capture && cmd.clear_block)

endmodule

@@ sv/adaptive_roughness_smoother.sv @@
// Top level: configuration registers, sequencer and datapath of the roughness smoother.
//
// Use: frames of two signed Q1.23 samples enter on start while busy is low, one
// word per cycle. Frames are held in a 64-entry store until one arrives with
// block_end set or the store fills; busy then rises and the whole block is
// played out on out_ch0/out_ch1 with result_valid high for one cycle per word,
// last_of_block marking the block's final word. The receiver cannot stall.
// After the block's last frame is taken, the blend amount is updated: the threshold
// step, the strength and intensity passes through the lane 0 multiplier, the cap
// step, the divide pass and the amount update; then the first frame is read. Each
// frame then takes lowpass multiply, lowpass update, blend multiply and output,
// with the next read overlapped on the output. In bypass (strength or intensity
// below 0.001) output follows the read and words stream one per cycle. busy falls
// in the cycle the last word is shown. Reset clears the block, the lowpass state
// and the blend amount and loads the register defaults; the user must write
// registers over the APB port only while busy is low, and the block itself does
// not enforce it.
module adaptive_roughness_smoother
    import ars_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample_ch0,
    input  logic signed [SAMPLE_W-1:0] sample_ch1,
    input  logic                       block_end,
    output logic                       result_valid,
    output logic signed [SAMPLE_W-1:0] out_ch0,
    output logic signed [SAMPLE_W-1:0] out_ch1,
    output logic                       last_of_block
);

    logic [COEF_W-1:0]    strength_reg;
    logic [COEF_W-1:0]    intensity_reg;
    logic [COEF_W-1:0]    coeff_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    ars_cmd_t             cmd;
    ars_status_t          status;
    frame_t               in_frame;
    frame_t               out_frame;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg  <= STRENGTH_RESET;
            intensity_reg <= INTENSITY_RESET;
            coeff_reg     <= COEFF_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_STRENGTH:  strength_reg  <= pwdata[COEF_W-1:0];
                REG_INTENSITY: intensity_reg <= pwdata[COEF_W-1:0];
                REG_COEFF:     coeff_reg     <= pwdata[COEF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_STRENGTH:  prdata = PDATA_W'(strength_reg);
            REG_INTENSITY: prdata = PDATA_W'(intensity_reg);
            REG_COEFF:     prdata = PDATA_W'(coeff_reg);
            default:       prdata = '0;
        endcase
    end

    assign in_frame = {sample_ch1, sample_ch0};

    ars_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .block_end (block_end),
        .busy      (busy),
        .status    (status),
        .cmd       (cmd)
    );

    ars_datapath u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .in_frame            (in_frame),
        .strength            (strength_reg),
        .detection_intensity (intensity_reg),
        .filter_coeff        (coeff_reg),
        .out_frame           (out_frame),
        .out_last            (last_of_block),
        .out_strobe          (result_valid)
    );

    assign out_ch0 = out_frame[0];
    assign out_ch1 = out_frame[1];

endmodule

@@ sim/adaptive_roughness_smoother_tb.sv @@
// Testbench for the roughness smoother: block stimulus, inline predictor and per-word checks.
`timescale 1ns / 1ps

module adaptive_roughness_smoother_tb;
    import ars_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int ITEM_TARGET  = 370;
    localparam int RAND_PHASES  = 7;
    localparam int SHOWN_ERRORS = 10;
    localparam int SAMPLE_MAX   = 8388607;
    localparam int SAMPLE_MIN   = -8388608;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register

    typedef enum int {
        STYLE_NOISE,
        STYLE_SMOOTH,
        STYLE_EXTREME,
        STYLE_STEPS
    } sample_style_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] ch0;
        logic signed [SAMPLE_W-1:0] ch1;
        logic                       last;
    } word_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       start;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch1;
    logic                       block_end;
    logic                       result_valid;
    logic signed [SAMPLE_W-1:0] out_ch0;
    logic signed [SAMPLE_W-1:0] out_ch1;
    logic                       last_of_block;

    // predictor state
    logic [COEF_W-1:0] strength_q;
    logic [COEF_W-1:0] intensity_q;
    logic [COEF_W-1:0] coeff_q;
    int                held_ch [BLOCK_FRAMES][CHANNELS];
    int                frames_held;
    int                prior_ch [CHANNELS];
    int                peak_step;
    int                lowpass_ch [CHANNELS];
    int                blend_q16;
    word_t             expected_words [$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    bit no_gaps     = 1'b0;

    adaptive_roughness_smoother u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%s", msg);
    endtask

    function automatic logic [COEF_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_STRENGTH:  return strength_q;
            REG_INTENSITY: return intensity_q;
            REG_COEFF:     return coeff_q;
            default:       return '0;
        endcase
    endfunction

    task automatic clear_model();
        strength_q  = STRENGTH_RESET;
        intensity_q = INTENSITY_RESET;
        coeff_q     = COEFF_RESET;
        frames_held = 0;
        peak_step   = 0;
        blend_q16   = 0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            prior_ch[c]   = 0;
            lowpass_ch[c] = 0;
        end
    endtask

    // Buffers one frame; on block end pushes the words the block plays out.
    task automatic predict_frame(input int s0, input int s1, input bit ends_block);
        int     x [CHANNELS];
        int     y_ch [CHANNELS];
        int     n;
        int     d;
        longint e;
        longint target;
        longint xl;
        longint z;
        longint y;
        word_t  w;
        x[0] = s0;
        x[1] = s1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            d = x[c] - prior_ch[c];
            if (d < 0)
                d = -d;
            if (d > peak_step)
                peak_step = d;
            prior_ch[c] = x[c];
            held_ch[frames_held][c] = x[c];
        end
        frames_held++;
        if (!ends_block && frames_held < BLOCK_FRAMES)
            return;

        n = frames_held;
        if (strength_q < BYPASS_LIMIT || intensity_q < BYPASS_LIMIT)
        begin
            // pass-through: blend amount and filter memory stay as they were
            for (int k = 0; k < n; k++)
            begin
                w.ch0  = SAMPLE_W'(held_ch[k][0]);
                w.ch1  = SAMPLE_W'(held_ch[k][1]);
                w.last = (k == n - 1);
                expected_words.push_back(w);
            end
        end
        else
        begin
            target = 0;
            // a lone frame has no roughness
            if (n >= 2 && peak_step > THRESHOLD)
            begin
                e = longint'(peak_step - THRESHOLD) * 10;
                if (e > ONE_Q23)
                    e = ONE_Q23;
                target = ((e * longint'(strength_q)) >> STR_SHIFT) * longint'(intensity_q)
                         >> INT_SHIFT;
            end
            if (target > CAP_Q16)
                target = CAP_Q16;
            blend_q16 = int'((9 * longint'(blend_q16) + target + V_ROUND) / 10);

            for (int k = 0; k < n; k++)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    xl = held_ch[k][c];
                    z  = (xl * longint'(coeff_q)
                          + longint'(lowpass_ch[c]) * (65536 - longint'(coeff_q))
                          + ROUND_HALF) >>> FRAC_W;
                    lowpass_ch[c] = int'(z);
                    y = xl + (((z - xl) * longint'(blend_q16) + ROUND_HALF) >>> FRAC_W);
                    if (y > SAMPLE_MAX)
                        y = SAMPLE_MAX;
                    if (y < SAMPLE_MIN)
                        y = SAMPLE_MIN;
                    y_ch[c] = int'(y);
                end
                w.ch0  = SAMPLE_W'(y_ch[0]);
                w.ch1  = SAMPLE_W'(y_ch[1]);
                w.last = (k == n - 1);
                expected_words.push_back(w);
            end
        end
        frames_held = 0;
        peak_step   = 0;
        for (int c = 0; c < CHANNELS; c++)
            prior_ch[c] = 0;
    endtask

    // Called at a falling edge; start may be left high for a back-to-back frame.
    task automatic send_frame(input int s0, input int s1, input bit ends_block);
        int gap;
        sample_ch0 = SAMPLE_W'(s0);
        sample_ch1 = SAMPLE_W'(s1);
        block_end  = ends_block;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_frame(s0, s1, ends_block);
        items_sent++;
        @(negedge clk);
        gap = 0;
        if (!no_gaps && $urandom_range(99) < 31)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (expected_words.size() != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        start   = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            REG_STRENGTH:  strength_q  = value[COEF_W-1:0];
            REG_INTENSITY: intensity_q = value[COEF_W-1:0];
            REG_COEFF:     coeff_q     = value[COEF_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read(input logic [REG_IDX_W-1:0] idx);
        logic [PDATA_W-1:0] want;
        want            = '0;
        want[COEF_W-1:0] = reg_value(idx);
        paddr   = {idx, 2'b00};
        pwrite  = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== want)
            note_error($sformatf("register %0d read: expected %h, got %h", idx, want, prdata));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Upper data bits carry junk; only the low 16 may land in a register.
    task automatic set_config(input logic [COEF_W-1:0] s, input logic [COEF_W-1:0] i,
                              input logic [COEF_W-1:0] c);
        wait_drained();
        reg_write(REG_STRENGTH, {16'($urandom), s});
        reg_write(REG_INTENSITY, {16'($urandom), i});
        reg_write(REG_COEFF, {16'($urandom), c});
    endtask

    function automatic int next_sample(input sample_style_t style, input int prior);
        logic signed [SAMPLE_W-1:0] r;
        int                         v;
        int                         step;
        case (style)
            STYLE_NOISE:
            begin
                r = SAMPLE_W'($urandom);
                v = int'(r);
            end
            STYLE_SMOOTH:
                v = prior + int'($urandom_range(0, 80000)) - 40000;
            STYLE_EXTREME:
                case ($urandom_range(4))
                    0:       v = SAMPLE_MAX;
                    1:       v = SAMPLE_MIN;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            default:
            begin
                // steps around the threshold up to past the cap
                step = int'($urandom_range(300000, 1400000));
                v = $urandom_range(1) ? prior + step : prior - step;
            end
        endcase
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        return v;
    endfunction

    task automatic random_block(input int frames, input bit fill_store);
        sample_style_t style;
        int            a;
        int            b;
        bit            ends;
        style = sample_style_t'($urandom_range(3));
        a = 0;
        b = 0;
        if (style == STYLE_SMOOTH)
        begin
            a = int'($urandom_range(0, 400000)) - 200000;
            b = int'($urandom_range(0, 400000)) - 200000;
        end
        for (int k = 0; k < frames; k++)
        begin
            a = next_sample(style, a);
            b = next_sample(style, b);
            // a full store ends the block whether or not block_end is set
            if (fill_store)
                ends = (k == frames - 1) && $urandom_range(1);
            else
                ends = (k == frames - 1);
            send_frame(a, b, ends);
        end
    endtask

    task automatic test_register_port();
        reg_read(REG_STRENGTH);
        reg_read(REG_INTENSITY);
        reg_read(REG_COEFF);
        reg_write(REG_COEFF, 32'hA5A5_1234);
        reg_write(REG_SPARE, 32'h0000_0000);
        reg_read(REG_STRENGTH);
        reg_read(REG_INTENSITY);
        reg_read(REG_COEFF);
        reg_write(REG_COEFF, {16'hFFFF, COEFF_RESET});
        reg_read(REG_COEFF);
    endtask

    task automatic test_edge_frames();
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);       // lone frame, roughness ignored
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);       // full-scale step, blend capped
        send_frame(0, 0, 1'b0);
        send_frame(1, -1, 1'b0);
        send_frame(-1, 1, 1'b1);
        send_frame(THRESHOLD, 0, 1'b0);                 // peak exactly at threshold
        send_frame(THRESHOLD, 0, 1'b1);
        send_frame(THRESHOLD + 1, -(THRESHOLD + 1), 1'b0);
        send_frame(THRESHOLD + 1, -(THRESHOLD + 1), 1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(0, 0, 1'b1);
    endtask

    task automatic test_bypass();
        set_config(COEF_W'(BYPASS_LIMIT - 1), INTENSITY_RESET, COEFF_RESET);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(-5, 5, 1'b0);
        send_frame(SAMPLE_MIN, 3, 1'b1);
        set_config(STRENGTH_RESET, 16'd0, COEFF_RESET);
        send_frame(123456, -654321, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        set_config(STRENGTH_RESET, COEF_W'(BYPASS_LIMIT - 1), COEFF_RESET);
        send_frame(7, -7, 1'b1);
        // lowest setting that still filters
        set_config(COEF_W'(BYPASS_LIMIT), COEF_W'(BYPASS_LIMIT), COEFF_RESET);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_random_blocks();
        int first;
        int goal;
        int len;
        int r;
        first = items_sent;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase)
                0: set_config(STRENGTH_RESET, INTENSITY_RESET, COEFF_RESET);
                1: set_config(16'hFFFF, 16'hFFFF, 16'h0000);
                2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: set_config(COEF_W'(BYPASS_LIMIT), COEF_W'(BYPASS_LIMIT),
                              COEF_W'($urandom));
                4: set_config(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
                5: set_config(COEF_W'($urandom_range(BYPASS_LIMIT - 1)), COEF_W'($urandom),
                              COEF_W'($urandom));
                default: set_config(COEF_W'($urandom_range(8192, 65535)), COEF_W'($urandom),
                                    COEF_W'($urandom_range(500, 20000)));
            endcase
            no_gaps = (phase == 3);
            if (phase == 1 || phase == 4)
                random_block(BLOCK_FRAMES, 1'b1);
            goal = first + (phase + 1) * ITEM_TARGET / RAND_PHASES;
            while (items_sent < goal)
            begin
                r = $urandom_range(99);
                if (r < 12)
                    len = 1;
                else if (r < 22)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(2, 12);
                random_block(len, 1'b0);
                if ($urandom_range(99) < 8)
                    wait_drained();
            end
        end
        no_gaps = 1'b0;
    endtask

    // every shown word is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_words.size() == 0)
                note_error($sformatf("unexpected word: %0d %0d last %0b",
                                     out_ch0, out_ch1, last_of_block));
            else
            begin
                want = expected_words.pop_front();
                if (out_ch0 !== want.ch0 || out_ch1 !== want.ch1
                    || last_of_block !== want.last)
                    note_error($sformatf("word mismatch: expected %0d %0d last %0b, got %0d %0d last %0b",
                                         want.ch0, want.ch1, want.last,
                                         out_ch0, out_ch1, last_of_block));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1
            || (psel === 1'b1 && penable === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("adaptive_roughness_smoother_tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        sample_ch0 = '0;
        sample_ch1 = '0;
        block_end  = 1'b0;
        clear_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_register_port();
        test_edge_frames();
        test_bypass();
        test_random_blocks();

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("adaptive_roughness_smoother_tb: PASS");
        else
            $display("adaptive_roughness_smoother_tb: FAIL");
        $finish;
    end

endmodule
